FILE: src/nmdf_pkg.sv
// Shared types and character constants for the decimal field to fixed-point converter.
// No dependencies.
package nmdf_pkg;

    // Character codes recognized in a numeric field
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Largest magnitude that fits a positive 32-bit signed value
    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

    // Digit counter width (frac_digits port width)
    localparam int FRAC_W = 3;

    // One result word
    typedef struct packed {
        logic signed [31:0]  value;
        logic [FRAC_W-1:0]   frac_digits;
        logic                invalid;
        logic                overflow;
    } res_t;

endpackage

FILE: src/nmea_decimal_field_to_fixed_core.sv
// Top level: input character register, field accumulator, result register.
// Depends on nmdf_pkg and nmdf_accum.
//
// Usage:
//   Input channel (char_valid / char_stall / char_code) carries one ASCII
//   character of a numeric text field per word. A ',' or '*' ends the field.
//   Output channel (result_valid / result_stall / value, frac_digits,
//   invalid, overflow) carries one word per terminator; value is the number
//   scaled by ten to frac_digits.
//   Throughput: one character per cycle while char_stall is low. A terminator
//   accepted into the input register moves on to the result register once
//   that register is free, and result_valid then rises. The multiply-add
//   by ten is a shift-and-add in the accumulator.
//   Reset clears the field state (start of a new field) and both valid flags.
//   While the result register is held by result_stall, non-terminator
//   characters keep being consumed; a terminator waits in the input
//   register and char_stall rises only then.
module nmea_decimal_field_to_fixed_core #(
    parameter int MAX_FRAC_DIGITS = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               char_valid,
    output logic                               char_stall,
    input  logic [7:0]                         char_code,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [31:0]                 value,
    output logic [nmdf_pkg::FRAC_W-1:0]        frac_digits,
    output logic                               invalid,
    output logic                               overflow
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           char_reg;
    logic                 out_valid_reg, out_valid_next;
    nmdf_pkg::res_t       res_reg;
    nmdf_pkg::res_t       res_comb;
    logic                 is_term;
    logic                 out_free;
    logic                 take;
    logic                 load_in;

    // Handshake control
    assign out_free   = !out_valid_reg || !result_stall;
    assign take       = in_valid_reg && (!is_term || out_free);
    assign char_stall = in_valid_reg && !take;
    assign load_in    = char_valid && !char_stall;

    assign in_valid_next  = load_in ? 1'b1 : (take ? 1'b0 : in_valid_reg);
    assign out_valid_next = (take && is_term) ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    // Field accumulator
    nmdf_accum #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_code (char_reg),
        .is_term   (is_term),
        .result    (res_comb)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_in)
            char_reg <= char_code;
        if (take && is_term)
            res_reg <= res_comb;
    end

    assign result_valid = out_valid_reg;
    assign value        = res_reg.value;
    assign frac_digits  = res_reg.frac_digits;
    assign invalid      = res_reg.invalid;
    assign overflow     = res_reg.overflow;

endmodule

FILE: src/nmdf_accum.sv
// Field accumulator: running magnitude, sign, point and error state, updated per character.
// Depends on nmdf_pkg.
module nmdf_accum #(
    parameter int MAX_FRAC_DIGITS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,        // consume char this cycle
    input  logic [7:0]          char_code,
    output logic                is_term,     // char is a field terminator
    output nmdf_pkg::res_t      result       // result for a terminator at char_code
);

    // Fraction limit clamped to what the counter can hold
    localparam int FracLimInt = (MAX_FRAC_DIGITS > 7) ? 7 : MAX_FRAC_DIGITS;
    localparam logic [nmdf_pkg::FRAC_W-1:0] FRAC_LIMIT = nmdf_pkg::FRAC_W'(FracLimInt);

    logic [30:0]                  mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic                         point_reg, point_next;
    logic [nmdf_pkg::FRAC_W-1:0]  frac_reg, frac_next;
    logic                         start_reg, start_next;
    logic                         bad_reg, bad_next;
    logic                         sat_reg, sat_next;

    logic                         is_digit;
    logic [3:0]                   digit;
    logic [34:0]                  mac;
    logic                         frac_full;
    logic [31:0]                  mag_ext;

    // Character classification
    assign is_term  = (char_code == nmdf_pkg::CHAR_COMMA) || (char_code == nmdf_pkg::CHAR_STAR);
    assign is_digit = (char_code >= nmdf_pkg::CHAR_ZERO) && (char_code <= nmdf_pkg::CHAR_NINE);
    assign digit    = char_code[3:0];

    // magnitude*10 + digit as two shifts and two adds
    assign mac = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {31'd0, digit};
    assign frac_full = point_reg && (frac_reg >= FRAC_LIMIT);

    // Result from the current field state
    assign mag_ext = {1'b0, mag_reg};
    always_comb
    begin
        if (bad_reg)
        begin
            result.value       = '0;
            result.frac_digits = '0;
            result.invalid     = 1'b1;
            result.overflow    = 1'b0;
        end
        else
        begin
            result.value       = neg_reg ? -$signed(mag_ext) : $signed(mag_ext);
            result.frac_digits = frac_reg;
            result.invalid     = 1'b0;
            result.overflow    = sat_reg;
        end
    end

    // Next field state
    always_comb
    begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        frac_next  = frac_reg;
        start_next = 1'b0;
        bad_next   = bad_reg;
        sat_next   = sat_reg;
        if (is_term)
        begin
            mag_next   = '0;
            neg_next   = 1'b0;
            point_next = 1'b0;
            frac_next  = '0;
            start_next = 1'b1;
            bad_next   = 1'b0;
            sat_next   = 1'b0;
        end
        else if (char_code == nmdf_pkg::CHAR_MINUS)
        begin
            if (start_reg)
                neg_next = 1'b1;
            else
                bad_next = 1'b1;
        end
        else if (char_code == nmdf_pkg::CHAR_POINT)
        begin
            if (point_reg)
                bad_next = 1'b1;
            else
                point_next = 1'b1;
        end
        else if (is_digit)
        begin
            if (!bad_reg && !frac_full)
            begin
                if (point_reg)
                    frac_next = frac_reg + nmdf_pkg::FRAC_W'(1);
                if (mac > {4'd0, nmdf_pkg::MAG_MAX})
                begin
                    mag_next = nmdf_pkg::MAG_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    mag_next = mac[30:0];
                end
            end
        end
        else
        begin
            bad_next = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            frac_reg  <= '0;
            start_reg <= 1'b1;
            bad_reg   <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else if (take)
        begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            point_reg <= point_next;
            frac_reg  <= frac_next;
            start_reg <= start_next;
            bad_reg   <= bad_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

FILE: sim/tb_nmea_decimal_field_to_fixed_core.sv
// Testbench for nmea_decimal_field_to_fixed_core: streams ASCII field text and checks
// every result word against an in-bench model of the field accumulator.
// Depends on nmdf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_nmea_decimal_field_to_fixed_core;

    localparam int FRAC_LIMIT  = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;
    localparam int LONG_HOLD   = 300;

    logic                              clk;
    logic                              rst_n;
    logic                              char_valid;
    logic                              char_stall;
    logic [7:0]                        char_code;
    logic                              result_valid;
    logic                              result_stall;
    logic signed [31:0]                value;
    logic [nmdf_pkg::FRAC_W-1:0]       frac_digits;
    logic                              invalid;
    logic                              overflow;

    // Traffic shaping for the sender and the receiver, and run counters
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_request;
    int chars_sent;
    int mismatches;
    int cycle_count;

    // Results still owed by the block, oldest first
    nmdf_pkg::res_t pending_fields[$];

    // Field accumulator model
    logic [30:0] acc_mag;
    logic        acc_neg;
    logic        acc_point;
    logic [2:0]  acc_frac;
    logic        acc_start;
    logic        acc_bad;
    logic        acc_sat;

    nmea_decimal_field_to_fixed_core #(
        .MAX_FRAC_DIGITS(FRAC_LIMIT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_code   (char_code),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .value       (value),
        .frac_digits (frac_digits),
        .invalid     (invalid),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_field();
        acc_mag   = '0;
        acc_neg   = 1'b0;
        acc_point = 1'b0;
        acc_frac  = '0;
        acc_start = 1'b1;
        acc_bad   = 1'b0;
        acc_sat   = 1'b0;
    endfunction

    // Advance the field model by one accepted character; queue a result on a terminator
    function automatic void accumulate_char(input logic [7:0] c);
        nmdf_pkg::res_t r;
        logic [34:0]    nxt;
        logic [31:0]    mag32;
        if (c == nmdf_pkg::CHAR_COMMA || c == nmdf_pkg::CHAR_STAR)
        begin
            if (acc_bad)
            begin
                r.value       = '0;
                r.frac_digits = '0;
                r.invalid     = 1'b1;
                r.overflow    = 1'b0;
            end
            else
            begin
                mag32         = {1'b0, acc_mag};
                r.value       = acc_neg ? 32'd0 - mag32 : mag32;
                r.frac_digits = acc_frac;
                r.invalid     = 1'b0;
                r.overflow    = acc_sat;
            end
            pending_fields.push_back(r);
            clear_field();
        end
        else
        begin
            if (c == nmdf_pkg::CHAR_MINUS)
            begin
                // minus only allowed as the first character
                if (acc_start)
                    acc_neg = 1'b1;
                else
                    acc_bad = 1'b1;
            end
            else if (c == nmdf_pkg::CHAR_POINT)
            begin
                if (acc_point)
                    acc_bad = 1'b1;
                else
                    acc_point = 1'b1;
            end
            else if (c >= nmdf_pkg::CHAR_ZERO && c <= nmdf_pkg::CHAR_NINE)
            begin
                // fractional digits past the limit are dropped
                if (!acc_bad && !(acc_point && acc_frac >= FRAC_LIMIT))
                begin
                    if (acc_point)
                        acc_frac = acc_frac + 3'd1;
                    nxt = {4'd0, acc_mag} * 35'd10 + {27'd0, c - nmdf_pkg::CHAR_ZERO};
                    if (nxt > {4'd0, nmdf_pkg::MAG_MAX})
                    begin
                        acc_mag = nmdf_pkg::MAG_MAX;
                        acc_sat = 1'b1;
                    end
                    else
                        acc_mag = nxt[30:0];
                end
            end
            else
                acc_bad = 1'b1;
            acc_start = 1'b0;
        end
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Compare one accepted result word with the oldest expectation
    task automatic check_result();
        nmdf_pkg::res_t e;
        if (pending_fields.size() == 0)
            note_mismatch($sformatf("unexpected word value=%0d frac=%0d inv=%0b ovf=%0b",
                                    value, frac_digits, invalid, overflow));
        else
        begin
            e = pending_fields.pop_front();
            if (value !== e.value)
                note_mismatch($sformatf("value exp %0d got %0d", e.value, value));
            if (frac_digits !== e.frac_digits)
                note_mismatch($sformatf("frac_digits exp %0d got %0d",
                                        e.frac_digits, frac_digits));
            if (invalid !== e.invalid)
                note_mismatch($sformatf("invalid exp %0b got %0b", e.invalid, invalid));
            if (overflow !== e.overflow)
                note_mismatch($sformatf("overflow exp %0b got %0b", e.overflow, overflow));
        end
    endtask

    // Receiver: checks results and drives result_stall, with optional long hold
    initial
    begin : receiver
        int hold_left;
        hold_left    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                check_result();
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one character and hold it until the block takes it
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        do
            @(posedge clk);
        while (char_stall);
        accumulate_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Sender goes quiet until every owed result has been taken
    task automatic wait_for_results();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_fields.size() != 0);
    endtask

    // One field: mostly well formed numbers, some broken, some raw noise
    task automatic send_random_field();
        byte unsigned body[$];
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                body.push_back(nmdf_pkg::CHAR_MINUS);
            // occasional long integer part to drive saturation
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 13) : $urandom_range(0, 5);
            repeat (n) body.push_back(8'(nmdf_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 99) < 60)
            begin
                body.push_back(nmdf_pkg::CHAR_POINT);
                n = $urandom_range(0, 8);
                repeat (n) body.push_back(8'(nmdf_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            end
            // broken field: stray minus, extra point or any byte at a random spot
            if (kind < 22)
            begin
                n = $urandom_range(0, 2);
                body.insert($urandom_range(0, body.size()),
                            (n == 0) ? nmdf_pkg::CHAR_MINUS
                                     : (n == 1) ? nmdf_pkg::CHAR_POINT
                                                : 8'($urandom_range(0, 255)));
            end
            body.push_back($urandom_range(0, 1) ? nmdf_pkg::CHAR_COMMA : nmdf_pkg::CHAR_STAR);
            foreach (body[i])
                send_char(body[i]);
        end
    endtask

    // Extremes and each special case of the field grammar
    task automatic test_directed_fields();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_text(",");                 // empty field
        send_text("-7,");               // negative integer
        send_text(".123456*");          // no integer part, fraction past limit
        send_text("9999999999,");       // saturation
        send_text("5-.");               // misplaced minus
        send_char(8'h00);               // illegal, lowest code
        send_text(".");                 // second point
        send_char(8'hFF);               // illegal, highest code
        send_text(",");
        wait_for_results();
    endtask

    task automatic test_random_fields(input int tx_pct, input int rx_pct, input int count);
        int target;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        target       = chars_sent + count;
        while (chars_sent < target)
            send_random_field();
        wait_for_results();
    endtask

    // Receiver holds off long while the sender keeps offering, so input stalls
    task automatic test_backpressure();
        int target;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = LONG_HOLD;
        target       = chars_sent + 60;
        while (chars_sent < target)
            send_random_field();
        wait_for_results();
    endtask

    // Five fields, then a full pause until everything is back, then twenty more and another pause
    task automatic test_pause_until_drained();
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
        repeat (5) send_random_field();
        wait_for_results();
        repeat (20) send_random_field();
        wait_for_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_code    = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 0;
        chars_sent   = 0;
        mismatches   = 0;
        clear_field();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_fields();
        test_random_fields(0, 0, 280);
        test_random_fields(67, 0, 280);
        test_random_fields(0, 67, 280);
        test_random_fields(12, 12, 280);
        test_backpressure();
        test_pause_until_drained();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_fields.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
